[src/fcpd_pkg.sv]
package fcpd_pkg;

  localparam int DIV_STEPS = 64;

  localparam logic [23:0] NS_PER_FRAME  = 24'd10000000;
  localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
  localparam logic [23:0] LEN_RESET     = 24'd12288000;

  // 10 ms is 78125 shifted left by 7
  localparam logic [16:0] FRAME_ODD   = 17'd78125;
  // floor(2^57 / 78125)
  localparam logic [40:0] FRAME_RECIP = 41'd1844674407370;

  typedef enum logic [1:0] {
    REG_FRAME_LEN = 2'd0,
    REG_OFFSET    = 2'd1,
    REG_EPOCH     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] ptp;
    logic [63:0] a;
    logic [63:0] b;
    logic        neg;
  } side_t;

endpackage

[src/fcpd_if.sv]
interface fcpd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_capture;
  logic [63:0] ptp_time_ns;

  modport source (output valid, output frame_capture, output ptp_time_ns, input ready);
  modport sink (input valid, input frame_capture, input ptp_time_ns, output ready);
endinterface

interface fcpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] measured_delta_ns;
  logic        [39:0] correction_frames;
  logic        [23:0] correction_units;
  logic               correction_negative;
  logic               length_error;

  modport source (output valid, output measured_delta_ns, output correction_frames,
                  output correction_units, output correction_negative,
                  output length_error, input ready);
  modport sink (input valid, input measured_delta_ns, input correction_frames,
                input correction_units, input correction_negative,
                input length_error, output ready);
endinterface

[src/fcpd_div.sv]
module fcpd_div import fcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_dividend,
  input  logic [23:0] in_divisor,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [63:0] out_quot,
  output logic [23:0] out_rem,
  output side_t       out_side
);

  logic        valid_r  [DIV_STEPS];
  logic [63:0] work_r   [DIV_STEPS];
  logic [23:0] rem_r    [DIV_STEPS];
  logic [23:0] dvs_r    [DIV_STEPS];
  side_t       side_r   [DIV_STEPS];

  logic        src_valid [DIV_STEPS];
  logic [63:0] src_work  [DIV_STEPS];
  logic [23:0] src_rem   [DIV_STEPS];
  logic [23:0] src_dvs   [DIV_STEPS];
  side_t       src_side  [DIV_STEPS];

  logic [24:0] shifted   [DIV_STEPS];
  logic        ge        [DIV_STEPS];
  logic [63:0] work_nxt  [DIV_STEPS];
  logic [23:0] rem_nxt   [DIV_STEPS];

  always_comb begin
    src_valid[0] = in_valid;
    src_work[0]  = in_dividend;
    src_rem[0]   = '0;
    src_dvs[0]   = in_divisor;
    src_side[0]  = in_side;
    for (int i = 1; i < DIV_STEPS; i++) begin
      src_valid[i] = valid_r[i-1];
      src_work[i]  = work_r[i-1];
      src_rem[i]   = rem_r[i-1];
      src_dvs[i]   = dvs_r[i-1];
      src_side[i]  = side_r[i-1];
    end
  end

  // one restoring quotient bit per stage
  always_comb begin
    for (int i = 0; i < DIV_STEPS; i++) begin
      shifted[i]  = {src_rem[i], src_work[i][63]};
      ge[i]       = shifted[i] >= {1'b0, src_dvs[i]};
      rem_nxt[i]  = ge[i] ? 24'(shifted[i] - {1'b0, src_dvs[i]}) : shifted[i][23:0];
      work_nxt[i] = {src_work[i][62:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_STEPS; i++) valid_r[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) valid_r[i] <= src_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        work_r[i] <= work_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        dvs_r[i]  <= src_dvs[i];
        side_r[i] <= src_side[i];
      end
    end
  end

  assign out_valid = valid_r[DIV_STEPS-1];
  assign out_quot  = work_r[DIV_STEPS-1];
  assign out_rem   = rem_r[DIV_STEPS-1];
  assign out_side  = side_r[DIV_STEPS-1];

endmodule

// divide by 10 ms in five stages: (x >> 7) / 78125 by reciprocal, one fixup
module fcpd_cdiv import fcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] in_dividend,
  input  side_t       in_side,
  output logic        out_valid,
  output logic [63:0] out_quot,
  output logic [23:0] out_rem,
  output side_t       out_side
);

  logic [56:0] y;
  logic [97:0] psum;
  logic [34:0] qd_lo;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [24:0] xl1_r, xl2_r, xl3_r;
  side_t       sd1_r, sd2_r, sd3_r, sd4_r, sd5_r;
  logic [63:0] pll_r, pll2_r;
  logic [40:0] plh_r;
  logic [56:0] phl_r;
  logic [33:0] phh_r, phh2_r;
  logic [57:0] mid_r;
  logic [40:0] q3_r, q4_r, quot5_r;
  logic [17:0] r4_r;
  logic [6:0]  lo4_r;
  logic [23:0] rem5_r;

  assign y     = in_dividend[63:7];
  assign psum  = {34'b0, pll2_r} + {8'b0, mid_r, 32'b0} + {phh2_r, 64'b0};
  assign qd_lo = {17'b0, q3_r[17:0]} * {18'b0, FRAME_ODD};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of y * reciprocal
      pll_r  <= {32'b0, y[31:0]} * {32'b0, FRAME_RECIP[31:0]};
      plh_r  <= {9'b0, y[31:0]} * {32'b0, FRAME_RECIP[40:32]};
      phl_r  <= {32'b0, y[56:32]} * {25'b0, FRAME_RECIP[31:0]};
      phh_r  <= {9'b0, y[56:32]} * {25'b0, FRAME_RECIP[40:32]};
      xl1_r  <= in_dividend[24:0];
      sd1_r  <= in_side;

      mid_r  <= {17'b0, plh_r} + {1'b0, phl_r};
      pll2_r <= pll_r;
      phh2_r <= phh_r;
      xl2_r  <= xl1_r;
      sd2_r  <= sd1_r;

      // estimate is exact or one short
      q3_r   <= psum[97:57];
      xl3_r  <= xl2_r;
      sd3_r  <= sd2_r;

      // remainder is below 2 * 78125, low bits suffice
      r4_r   <= xl3_r[24:7] - qd_lo[17:0];
      q4_r   <= q3_r;
      lo4_r  <= xl3_r[6:0];
      sd4_r  <= sd3_r;

      if (r4_r >= {1'b0, FRAME_ODD}) begin
        quot5_r <= q4_r + 41'd1;
        rem5_r  <= {17'(r4_r - {1'b0, FRAME_ODD}), lo4_r};
      end else begin
        quot5_r <= q4_r;
        rem5_r  <= {r4_r[16:0], lo4_r};
      end
      sd5_r  <= sd4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_quot  = {23'b0, quot5_r};
  assign out_rem   = rem5_r;
  assign out_side  = sd5_r;

endmodule

[src/frame_clock_ptp_delta_unit.sv]
// channel  dir  payload                                         handshake
// in_ch    in   frame_capture[63:0], ptp_time_ns[63:0]          valid/ready
// out_ch   out  measured_delta_ns, correction_frames/units,     valid/ready
//               correction_negative, length_error
// cfg      in   cfg_index[1:0], cfg_wdata[31:0]                 cfg_we
//
// one transaction per cycle sustained while out_ch is not stalled
// the pipeline is a 64-stage bit-per-stage divider by the frame length,
// two 5-stage reciprocal dividers by 10 ms and 8 glue stages
// synchronous active-low reset empties the pipeline and loads register defaults
// a stall on out_ch freezes every stage at once and drops in_ch.ready
module frame_clock_ptp_delta_unit import fcpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fcpd_in_if.sink     in_ch,
  fcpd_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [23:0] len_r;
  logic [31:0] off_r;
  logic [31:0] epoch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RESET;
      off_r   <= '0;
      epoch_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LEN: len_r   <= cfg_wdata[23:0];
        REG_OFFSET:    off_r   <= cfg_wdata;
        REG_EPOCH:     epoch_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic        en;
  logic [63:0] off64;
  logic        outv_r;

  assign en           = !outv_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign off64        = {{32{off_r[31]}}, off_r};

  // stage 1: partial products
  logic        s1v_r;
  logic [47:0] pu_r;
  logic [55:0] plo_r;
  logic [31:0] phi_r;
  logic [61:0] ep_r;
  logic [63:0] ptp1_r;

  // stage 2: frame whole ns
  logic        s2v_r;
  logic [63:0] whole_r;
  logic [63:0] ep2_r;
  logic [63:0] ptp2_r;
  logic [47:0] dvd1_r;

  logic        d1v, d2v, d3v;
  logic [63:0] d1q, d2q, d3q;
  logic [23:0] d1rem, d2rem, d3rem;
  side_t       d1s, d2s, d3s, side1, side2, side3;

  logic        s3v_r, s4v_r, s5v_r, s6v_r, s7v_r;
  logic [63:0] fns_r, pe_r, base_r, meas5_r, corr_r, meas6_r, mag_r;
  logic        neg_r;
  logic [47:0] prod_r;
  side_t       s7s_r;

  logic [63:0] meas_o_r;
  logic [39:0] frm_o_r;
  logic [23:0] unt_o_r;
  logic        neg_o_r, err_o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1v_r  <= 1'b0;
      s2v_r  <= 1'b0;
      s3v_r  <= 1'b0;
      s4v_r  <= 1'b0;
      s5v_r  <= 1'b0;
      s6v_r  <= 1'b0;
      s7v_r  <= 1'b0;
      outv_r <= 1'b0;
    end else if (en) begin
      s1v_r  <= in_ch.valid;
      s2v_r  <= s1v_r;
      s3v_r  <= d1v;
      s4v_r  <= s3v_r;
      s5v_r  <= s4v_r;
      s6v_r  <= s5v_r;
      s7v_r  <= d2v;
      outv_r <= d3v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pu_r    <= {24'b0, in_ch.frame_capture[23:0]} * {24'b0, NS_PER_FRAME};
      plo_r   <= {24'b0, in_ch.frame_capture[55:24]} * {32'b0, NS_PER_FRAME};
      phi_r   <= {24'b0, in_ch.frame_capture[63:56]} * {8'b0, NS_PER_FRAME};
      ep_r    <= {30'b0, epoch_r} * {32'b0, NS_PER_SECOND};
      ptp1_r  <= in_ch.ptp_time_ns;

      whole_r <= {8'b0, plo_r} + {phi_r, 32'b0};
      ep2_r   <= {2'b0, ep_r};
      ptp2_r  <= ptp1_r;
      dvd1_r  <= pu_r;

      fns_r   <= d1s.b + d1q;
      pe_r    <= d1s.ptp - d1s.a;
      base_r  <= pe_r - fns_r;
      meas5_r <= base_r + off64;
      corr_r  <= base_r - off64;
      meas6_r <= meas5_r;
      neg_r   <= corr_r[63];
      mag_r   <= corr_r[63] ? (64'd0 - corr_r) : corr_r;

      prod_r  <= {24'b0, d2rem} * {24'b0, len_r};
      s7s_r   <= '{ptp: '0, a: d2s.a, b: {24'b0, d2q[39:0]}, neg: d2s.neg};

      if (len_r == '0) begin
        meas_o_r <= '0;
        frm_o_r  <= '0;
        unt_o_r  <= '0;
        neg_o_r  <= 1'b0;
        err_o_r  <= 1'b1;
      end else begin
        meas_o_r <= d3s.a;
        frm_o_r  <= d3s.neg ? ~d3s.b[39:0] : d3s.b[39:0];
        unt_o_r  <= d3s.neg ? ~d3q[23:0] : d3q[23:0];
        neg_o_r  <= d3s.neg;
        err_o_r  <= 1'b0;
      end
    end
  end

  assign side1 = '{ptp: ptp2_r, a: ep2_r, b: whole_r, neg: 1'b0};
  assign side2 = '{ptp: '0, a: meas6_r, b: '0, neg: neg_r};
  assign side3 = s7s_r;

  fcpd_div u_div_unit (
    .clk, .rst_n, .en,
    .in_valid    (s2v_r),
    .in_dividend ({16'b0, dvd1_r}),
    .in_divisor  (len_r),
    .in_side     (side1),
    .out_valid   (d1v),
    .out_quot    (d1q),
    .out_rem     (d1rem),
    .out_side    (d1s)
  );

  fcpd_cdiv u_div_frame (
    .clk, .rst_n, .en,
    .in_valid    (s6v_r),
    .in_dividend (mag_r),
    .in_side     (side2),
    .out_valid   (d2v),
    .out_quot    (d2q),
    .out_rem     (d2rem),
    .out_side    (d2s)
  );

  fcpd_cdiv u_div_corr (
    .clk, .rst_n, .en,
    .in_valid    (s7v_r),
    .in_dividend ({16'b0, prod_r}),
    .in_side     (side3),
    .out_valid   (d3v),
    .out_quot    (d3q),
    .out_rem     (d3rem),
    .out_side    (d3s)
  );

  assign out_ch.valid               = outv_r;
  assign out_ch.measured_delta_ns   = meas_o_r;
  assign out_ch.correction_frames   = frm_o_r;
  assign out_ch.correction_units    = unt_o_r;
  assign out_ch.correction_negative = neg_o_r;
  assign out_ch.length_error        = err_o_r;

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.length_error |->
      out_ch.measured_delta_ns == '0 && out_ch.correction_frames == '0 &&
      out_ch.correction_units == '0 && !out_ch.correction_negative)
    else $error("length error with nonzero fields");
  a_frame_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
    d2v |-> d2q[63:40] == '0)
    else $error("correction frame quotient overflows 40 bits");
  a_unit_rem_unused: assert property (@(posedge clk) disable iff (!rst_n)
    d1v && len_r != '0 |-> d1rem < len_r)
    else $error("divider remainder out of range");
  a_corr_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    d3v |-> d3rem < NS_PER_FRAME)
    else $error("correction remainder out of range");
`endif

endmodule
